### design/tsr_pkg.sv
`default_nettype none

package tsr_pkg;

    localparam int TIC_W    = 24;
    localparam int WIDE_W   = 26;
    localparam int SLOT_W   = 4;
    localparam int BACKUP_DEPTH = 16;
    localparam int BACKUP_W = $clog2(BACKUP_DEPTH);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [TIC_W-1:0] TICS_MAX = {TIC_W{1'b1}};
    localparam logic signed [8:0] WINDOW = 9'sd64;
    localparam logic signed [WIDE_W-1:0] BLOCK = 26'sd256;

    typedef enum logic [2:0] {
        VERDICT_SETUP       = 3'd0,
        VERDICT_EXIT        = 3'd1,
        VERDICT_EXIT_IGNORE = 3'd2,
        VERDICT_DUPLICATE   = 3'd3,
        VERDICT_OUT_OF_ORDER = 3'd4,
        VERDICT_MISSED      = 3'd5,
        VERDICT_ACCEPTED    = 3'd6
    } verdict_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NODE_MASK      = 1'd0,
        REG_HOLDOFF_LOAD   = 1'd1
    } cfg_reg_t;

endpackage

`default_nettype wire

### design/tic_sequence_receiver.sv
`default_nettype none

// Tic sequence receiver: one packet header per item on s_*, one verdict item per header on
// m_*. An item waits in the input register, where the sending node's counters are read,
// updated and written back, and then sits in the output register until taken; a new header
// is taken every cycle while the output side keeps up, so the rate is one item per clock.
// Low tic bytes over 64 from the local low byte move one block toward the local tic.
// Configuration writes on cfg_* are always taken and must be made while no item is in flight.
module tic_sequence_receiver
    import tsr_pkg::*;
#(
    parameter int NODES = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // node, player_byte, start_low, tic_count, retransmit_low, local_tic
    input  wire logic [63:0]           s_tdata,
    // flag_exit, flag_retransmit, flag_setup, flag_kill
    input  wire logic [3:0]            s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // player_slot, real_start, copy_offset, copy_count, first_slot, node_tics_now, resend_from
    output logic [103:0]               m_tdata,
    // verdict, kill_seen
    output logic [3:0]                 m_tuser
);

    localparam int NSTATE = (NODES < 4) ? NODES : 4;
    localparam int NIDX   = $clog2(NSTATE);

    function automatic logic signed [WIDE_W-1:0] widen_tic(
        input logic [7:0]       low,
        input logic [TIC_W-1:0] here_tic
    );
        logic signed [8:0]        diff;
        logic signed [WIDE_W-1:0] plain;
        diff  = $signed({1'b0, low}) - $signed({1'b0, here_tic[7:0]});
        plain = $signed({2'b00, here_tic[TIC_W-1:8], low});
        if (diff > WINDOW)
            return plain - BLOCK;
        else if (diff < -WINDOW)
            return plain + BLOCK;
        else
            return plain;
    endfunction

    // configuration
    logic [3:0] node_mask_reg;
    logic [7:0] holdoff_load_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_mask_reg    <= 4'd1;
            holdoff_load_reg <= 8'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NODE_MASK:    node_mask_reg    <= cfg_data[3:0];
                REG_HOLDOFF_LOAD: holdoff_load_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    logic             in_valid_reg;
    logic [1:0]       node_reg;
    logic [6:0]       player_reg;
    logic [7:0]       start_low_reg;
    logic [7:0]       count_reg;
    logic [7:0]       rt_low_reg;
    logic [TIC_W-1:0] local_tic_reg;
    logic             f_exit_reg;
    logic             f_rt_reg;
    logic             f_setup_reg;
    logic             f_kill_reg;

    logic out_valid_reg;
    logic advance;
    logic in_fire;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            node_reg      <= s_tdata[1:0];
            player_reg    <= s_tdata[8:2];
            start_low_reg <= s_tdata[17:10];
            count_reg     <= s_tdata[25:18];
            rt_low_reg    <= s_tdata[33:26];
            local_tic_reg <= s_tdata[57:34];
            f_exit_reg    <= s_tuser[0];
            f_rt_reg      <= s_tuser[1];
            f_setup_reg   <= s_tuser[2];
            f_kill_reg    <= s_tuser[3];
        end
    end

    // per-node state
    logic [TIC_W-1:0]         node_tics_reg      [NSTATE];
    logic [7:0]               resend_holdoff_reg [NSTATE];
    logic signed [WIDE_W-1:0] resend_tic_reg     [NSTATE];
    logic [NSTATE-1:0]        need_resend_reg;
    logic [NSTATE-1:0]        node_left_reg;

    logic                     in_range;
    logic [NIDX-1:0]          idx;
    logic signed [WIDE_W-1:0] rstart;
    logic signed [WIDE_W-1:0] rend;
    logic signed [WIDE_W-1:0] rt_wide;
    logic signed [WIDE_W-1:0] nt_s;
    logic signed [WIDE_W-1:0] off_wide;
    logic [TIC_W-1:0]         nt;
    logic [TIC_W-1:0]         newt;
    logic [TIC_W-1:0]         cnt_wide;
    logic                     in_game;

    logic [TIC_W-1:0]         tics_next;
    logic [7:0]               holdoff_next;
    logic signed [WIDE_W-1:0] resend_next;
    logic                     need_next;
    logic                     left_next;

    verdict_t                 verdict;
    logic                     kill;
    logic [7:0]               off;
    logic [7:0]               cnt;
    logic [SLOT_W-1:0]        slot;
    logic [TIC_W-1:0]         now;
    logic signed [WIDE_W-1:0] rfrom;

    assign in_range = int'(node_reg) < NODES;
    assign idx      = node_reg[NIDX-1:0];
    assign rstart   = widen_tic(start_low_reg, local_tic_reg);
    assign rt_wide  = widen_tic(rt_low_reg, local_tic_reg);
    assign rend     = rstart + $signed({18'd0, count_reg});
    assign nt       = node_tics_reg[idx];
    assign nt_s     = $signed({2'b00, nt});
    assign off_wide = nt_s - rstart;
    assign newt     = (rend > $signed({2'b00, TICS_MAX})) ? TICS_MAX : rend[TIC_W-1:0];
    assign cnt_wide = newt - nt;
    assign in_game  = node_mask_reg[node_reg] && !node_left_reg[idx];

    always_comb
    begin
        tics_next    = nt;
        holdoff_next = resend_holdoff_reg[idx];
        resend_next  = resend_tic_reg[idx];
        need_next    = need_resend_reg[idx];
        left_next    = node_left_reg[idx];
        verdict      = VERDICT_DUPLICATE;
        kill         = 1'b0;
        off          = 8'd0;
        cnt          = 8'd0;
        slot         = '0;
        if (f_setup_reg)
        begin
            verdict = VERDICT_SETUP;
        end
        else if (f_exit_reg)
        begin
            if (in_game)
            begin
                left_next = 1'b1;
                verdict   = VERDICT_EXIT;
            end
            else
            begin
                verdict = VERDICT_EXIT_IGNORE;
            end
        end
        else
        begin
            kill = f_kill_reg;
            if (resend_holdoff_reg[idx] == 8'd0 && f_rt_reg)
            begin
                resend_next  = rt_wide;
                holdoff_next = holdoff_load_reg;
            end
            else if (resend_holdoff_reg[idx] != 8'd0)
            begin
                holdoff_next = resend_holdoff_reg[idx] - 8'd1;
            end
            if (rend == nt_s)
            begin
                verdict = VERDICT_DUPLICATE;
            end
            else if (rend < nt_s)
            begin
                verdict = VERDICT_OUT_OF_ORDER;
            end
            else if (rstart > nt_s)
            begin
                need_next = 1'b1;
                verdict   = VERDICT_MISSED;
            end
            else
            begin
                need_next = 1'b0;
                off       = off_wide[7:0];
                slot      = SLOT_W'(nt[BACKUP_W-1:0]);
                cnt       = cnt_wide[7:0];
                tics_next = newt;
                verdict   = VERDICT_ACCEPTED;
            end
        end
        now   = tics_next;
        rfrom = resend_next;
        if (!in_range)
        begin
            verdict = VERDICT_DUPLICATE;
            kill    = 1'b0;
            off     = 8'd0;
            cnt     = 8'd0;
            slot    = '0;
            now     = '0;
            rfrom   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTATE; i++)
            begin
                node_tics_reg[i]      <= '0;
                resend_holdoff_reg[i] <= '0;
                resend_tic_reg[i]     <= '0;
            end
            need_resend_reg <= '0;
            node_left_reg   <= '0;
        end
        else if (in_fire && in_range)
        begin
            node_tics_reg[idx]      <= tics_next;
            resend_holdoff_reg[idx] <= holdoff_next;
            resend_tic_reg[idx]     <= resend_next;
            need_resend_reg[idx]    <= need_next;
            node_left_reg[idx]      <= left_next;
        end
    end

    // output register
    verdict_t                 verdict_reg;
    logic                     kill_reg;
    logic [6:0]               slot_player_reg;
    logic signed [WIDE_W-1:0] real_start_reg;
    logic [7:0]               off_reg;
    logic [7:0]               cnt_reg;
    logic [SLOT_W-1:0]        first_slot_reg;
    logic [TIC_W-1:0]         now_reg;
    logic signed [WIDE_W-1:0] rfrom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            verdict_reg     <= verdict;
            kill_reg        <= kill;
            slot_player_reg <= player_reg;
            real_start_reg  <= rstart;
            off_reg         <= off;
            cnt_reg         <= cnt;
            first_slot_reg  <= slot;
            now_reg         <= now;
            rfrom_reg       <= rfrom;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, rfrom_reg, now_reg, first_slot_reg, cnt_reg, off_reg,
                       real_start_reg, slot_player_reg};
    assign m_tuser  = {kill_reg, verdict_reg};

    // checks
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (out_valid_reg && !m_tready))
        else $error("input stalled without a stalled output");

    a_store_range_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && verdict_reg != VERDICT_ACCEPTED)
            |-> (off_reg == 8'd0 && cnt_reg == 8'd0 && first_slot_reg == '0))
        else $error("store range given for a packet that was not accepted");

    a_left_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((~node_left_reg & $past(node_left_reg)) == '0))
        else $error("node left mark cleared");

    for (genvar g = 0; g < NSTATE; g++)
    begin : g_mono
        a_tics_grow: assert property (@(posedge clk) disable iff (!rst_n)
            1'b1 |=> (node_tics_reg[g] >= $past(node_tics_reg[g])))
            else $error("node tic count went backward");
    end

endmodule

`default_nettype wire
